// ===== sv/dlt_pkg.sv =====
// ----------------------------------------------------------------------------
// dlt_pkg: shared types and constants of the description language tokenizer
// Scan modes, token kinds, error codes, character codes and the beat layout.
// ----------------------------------------------------------------------------
package dlt_pkg;

   localparam int OFFSET_BITS   = 32;
   localparam int POSITION_BITS = 24;

   // field widths of a result beat
   localparam int KIND_BITS     = 4;
   localparam int ERR_BITS      = 2;
   localparam int OFF_FIELD_BITS = 32;
   localparam int POS_FIELD_BITS = 24;

   // response queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // scan modes
   localparam logic [3:0] M_IDLE     = 4'd0;
   localparam logic [3:0] M_COMMENT  = 4'd1;
   localparam logic [3:0] M_SIGN     = 4'd2;
   localparam logic [3:0] M_INT      = 4'd3;
   localparam logic [3:0] M_FRAC     = 4'd4;
   localparam logic [3:0] M_EXP_E    = 4'd5;
   localparam logic [3:0] M_EXP_SIGN = 4'd6;
   localparam logic [3:0] M_EXP_DIG  = 4'd7;
   localparam logic [3:0] M_IDENT    = 4'd8;
   localparam logic [3:0] M_STR      = 4'd9;
   localparam logic [3:0] M_STR_ESC  = 4'd10;
   localparam logic [3:0] M_HALT     = 4'd11;

   // token kinds
   localparam logic [KIND_BITS-1:0] K_END      = 4'd0;
   localparam logic [KIND_BITS-1:0] K_IDENT    = 4'd1;
   localparam logic [KIND_BITS-1:0] K_NUMBER   = 4'd2;
   localparam logic [KIND_BITS-1:0] K_STRING   = 4'd3;
   localparam logic [KIND_BITS-1:0] K_LBRACKET = 4'd4;
   localparam logic [KIND_BITS-1:0] K_RBRACKET = 4'd5;
   localparam logic [KIND_BITS-1:0] K_LBRACE   = 4'd6;
   localparam logic [KIND_BITS-1:0] K_RBRACE   = 4'd7;
   localparam logic [KIND_BITS-1:0] K_LPAREN   = 4'd8;
   localparam logic [KIND_BITS-1:0] K_RPAREN   = 4'd9;
   localparam logic [KIND_BITS-1:0] K_COLON    = 4'd10;
   localparam logic [KIND_BITS-1:0] K_SEMI     = 4'd11;
   localparam logic [KIND_BITS-1:0] K_EQUALS   = 4'd12;
   localparam logic [KIND_BITS-1:0] K_COMMA    = 4'd13;
   localparam logic [KIND_BITS-1:0] K_DOT      = 4'd14;
   localparam logic [KIND_BITS-1:0] K_ERROR    = 4'd15;

   // error codes
   localparam logic [ERR_BITS-1:0] E_NONE       = 2'd0;
   localparam logic [ERR_BITS-1:0] E_OPEN_STR   = 2'd1;
   localparam logic [ERR_BITS-1:0] E_BAD_EXP    = 2'd2;
   localparam logic [ERR_BITS-1:0] E_UNEXPECTED = 2'd3;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_E   = 8'h65;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;

   typedef struct packed {
      logic [3:0]               mode;
      logic [OFFSET_BITS-1:0]   off;
      logic [POSITION_BITS-1:0] line;
      logic [POSITION_BITS-1:0] col;
      logic [OFFSET_BITS-1:0]   ts_off;
      logic [POSITION_BITS-1:0] ts_line;
      logic [POSITION_BITS-1:0] ts_col;
   } scan_state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]      kind;
      logic [ERR_BITS-1:0]       err;
      logic [OFF_FIELD_BITS-1:0] off;
      logic [OFF_FIELD_BITS-1:0] len;
      logic [POS_FIELD_BITS-1:0] line;
      logic [POS_FIELD_BITS-1:0] col;
      logic                      last;
   } result_type;

   // results of one accepted byte, in delivery order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } scan_out_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return is_digit(b) || ((b >= CH_LO_A) && (b <= CH_LO_Z)) ||
             ((b >= CH_UP_A) && (b <= CH_UP_Z)) || (b == CH_UNDER);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   // symbol kind of a byte, K_END when it is no symbol
   function automatic logic [KIND_BITS-1:0] sym_kind(input logic [7:0] b);
      logic [KIND_BITS-1:0] k;
      case (b)
         8'h5B:   k = K_LBRACKET;
         8'h5D:   k = K_RBRACKET;
         8'h7B:   k = K_LBRACE;
         8'h7D:   k = K_RBRACE;
         8'h28:   k = K_LPAREN;
         8'h29:   k = K_RPAREN;
         8'h3A:   k = K_COLON;
         8'h3B:   k = K_SEMI;
         8'h3D:   k = K_EQUALS;
         8'h2C:   k = K_COMMA;
         8'h2E:   k = K_DOT;
         default: k = K_END;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/description_language_tokenizer.sv =====
// ----------------------------------------------------------------------------
// description_language_tokenizer: byte-stream lexer
// Scans description text one byte per beat and emits token beats.
// ----------------------------------------------------------------------------
// The tokenizer takes one text byte per req beat while req_stall is low. Each
// byte is scanned in the cycle it is accepted and its results (none, one or
// two token beats) go into a four-entry result queue; if that was empty, the
// first shows on the rsp port in the next cycle. The rsp port delivers one
// token beat per cycle while rsp_stall is low, so a byte that both closes a
// token and makes another (a symbol after an identifier) gives two rsp beats.
// req_stall rises whenever the queue holds more than two beats, so the
// sustained rate is one byte per cycle as long as most bytes yield at most
// one token and the consumer keeps up. rsp_last_of_run marks the final beat
// of one byte. End of text (req_end_of_text or a zero byte) flushes a pending
// token and emits an End token, or an error beat if it is unfinished, and
// restarts offsets, lines and columns unless a zero byte gives an error. On
// other errors, bytes are ignored until req_end_of_text restarts silently.
// ----------------------------------------------------------------------------
module description_language_tokenizer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [1:0]  rsp_error_code,
   output logic [31:0] rsp_start_offset,
   output logic [31:0] rsp_token_length,
   output logic [23:0] rsp_start_line,
   output logic [23:0] rsp_start_column,
   output logic        rsp_last_of_run
);

   dlt_pkg::scan_state_type state_ff;
   dlt_pkg::scan_state_type state_in;
   dlt_pkg::scan_out_type   scan_res;
   dlt_pkg::result_type     head;
   logic                    room_for_two;
   logic                    req_take;

   // hold off new bytes unless the queue can absorb a two-token burst
   assign req_stall = !room_for_two;
   assign req_take  = req_valid && !req_stall;

   dlt_scan u_scan (
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .cur         (state_ff),
      .nxt         (state_in),
      .res         (scan_res)
   );

   // advance the scan state only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode    <= dlt_pkg::M_IDLE;
         state_ff.off     <= '0;
         state_ff.line    <= dlt_pkg::POSITION_BITS'(1);
         state_ff.col     <= dlt_pkg::POSITION_BITS'(1);
         state_ff.ts_off  <= '0;
         state_ff.ts_line <= dlt_pkg::POSITION_BITS'(1);
         state_ff.ts_col  <= dlt_pkg::POSITION_BITS'(1);
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   dlt_rsp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (req_take),
      .push_data    (scan_res),
      .room_for_two (room_for_two),
      .head_valid   (rsp_valid),
      .head_take    (!rsp_stall),
      .head         (head)
   );

   // drive the rsp fields from the queue head
   assign rsp_token_kind   = head.kind;
   assign rsp_error_code   = head.err;
   assign rsp_start_offset = head.off;
   assign rsp_token_length = head.len;
   assign rsp_start_line   = head.line;
   assign rsp_start_column = head.col;
   assign rsp_last_of_run  = head.last;

endmodule

// ===== sv/dlt_scan.sv =====
// ----------------------------------------------------------------------------
// dlt_scan: per-byte lexer step
// Next scan state and up to two result beats for one input beat.
// ----------------------------------------------------------------------------
module dlt_scan (
   input  logic [7:0]               text_byte,
   input  logic                     end_of_text,
   input  dlt_pkg::scan_state_type  cur,
   output dlt_pkg::scan_state_type  nxt,
   output dlt_pkg::scan_out_type    res
);

   logic                          a_v;
   logic                          b_v;
   dlt_pkg::result_type           a_r;
   dlt_pkg::result_type           b_r;
   logic                          idle_go;
   logic                          end_go;
   logic                          end_err;
   logic                          do_adv;
   logic                          clear;
   logic [dlt_pkg::OFFSET_BITS-1:0] len_d;
   logic [dlt_pkg::KIND_BITS-1:0] sk;

   function automatic dlt_pkg::result_type at_start(
      input dlt_pkg::scan_state_type s,
      input logic [dlt_pkg::KIND_BITS-1:0] kind,
      input logic [dlt_pkg::ERR_BITS-1:0] err,
      input logic [dlt_pkg::OFFSET_BITS-1:0] len
   );
      dlt_pkg::result_type r;
      r.kind = kind;
      r.err  = err;
      r.off  = dlt_pkg::OFF_FIELD_BITS'(s.ts_off);
      r.len  = dlt_pkg::OFF_FIELD_BITS'(len);
      r.line = dlt_pkg::POS_FIELD_BITS'(s.ts_line);
      r.col  = dlt_pkg::POS_FIELD_BITS'(s.ts_col);
      r.last = 1'b0;
      return r;
   endfunction

   function automatic dlt_pkg::result_type at_here(
      input dlt_pkg::scan_state_type s,
      input logic [dlt_pkg::KIND_BITS-1:0] kind,
      input logic [dlt_pkg::ERR_BITS-1:0] err,
      input logic len_one
   );
      dlt_pkg::result_type r;
      r.kind = kind;
      r.err  = err;
      r.off  = dlt_pkg::OFF_FIELD_BITS'(s.off);
      r.len  = dlt_pkg::OFF_FIELD_BITS'(len_one);
      r.line = dlt_pkg::POS_FIELD_BITS'(s.line);
      r.col  = dlt_pkg::POS_FIELD_BITS'(s.col);
      r.last = 1'b0;
      return r;
   endfunction

   assign len_d = cur.off - cur.ts_off;
   assign sk    = dlt_pkg::sym_kind(text_byte);

   always_comb begin
      nxt     = cur;
      a_v     = 1'b0;
      b_v     = 1'b0;
      a_r     = '0;
      b_r     = '0;
      idle_go = 1'b0;
      end_go  = 1'b0;
      end_err = 1'b0;
      do_adv  = 1'b0;
      clear   = 1'b0;

      if (end_of_text) begin
         end_go = (cur.mode != dlt_pkg::M_HALT);
         clear  = 1'b1;
      end else if (cur.mode == dlt_pkg::M_HALT) begin
         nxt = cur;
      end else if (text_byte == dlt_pkg::CH_NUL) begin
         end_go = 1'b1;
      end else begin
         do_adv = 1'b1;
         case (cur.mode)
            dlt_pkg::M_COMMENT: begin
               if (text_byte == dlt_pkg::CH_NL) nxt.mode = dlt_pkg::M_IDLE;
            end
            dlt_pkg::M_STR: begin
               if (text_byte == dlt_pkg::CH_NL) begin
                  a_v = 1'b1;
                  a_r = at_start(cur, dlt_pkg::K_ERROR, dlt_pkg::E_OPEN_STR, '0);
                  nxt.mode = dlt_pkg::M_HALT;
               end else if (text_byte == dlt_pkg::CH_BSLASH) begin
                  nxt.mode = dlt_pkg::M_STR_ESC;
               end else if (text_byte == dlt_pkg::CH_QUOTE) begin
                  a_v = 1'b1;
                  a_r = at_start(cur, dlt_pkg::K_STRING, dlt_pkg::E_NONE,
                                 len_d + 1'b1);
                  nxt.mode = dlt_pkg::M_IDLE;
               end
            end
            dlt_pkg::M_STR_ESC: begin
               if (text_byte == dlt_pkg::CH_NL) begin
                  a_v = 1'b1;
                  a_r = at_start(cur, dlt_pkg::K_ERROR, dlt_pkg::E_OPEN_STR, '0);
                  nxt.mode = dlt_pkg::M_HALT;
               end else begin
                  nxt.mode = dlt_pkg::M_STR;
               end
            end
            dlt_pkg::M_SIGN: begin
               if (dlt_pkg::is_digit(text_byte)) begin
                  nxt.mode = dlt_pkg::M_INT;
               end else begin
                  a_v = 1'b1;
                  a_r = at_start(cur, dlt_pkg::K_ERROR, dlt_pkg::E_UNEXPECTED, '0);
                  nxt.mode = dlt_pkg::M_HALT;
               end
            end
            dlt_pkg::M_INT, dlt_pkg::M_FRAC: begin
               if (dlt_pkg::is_digit(text_byte)) begin
                  nxt.mode = cur.mode;
               end else if ((text_byte == dlt_pkg::CH_DOT) &&
                            (cur.mode == dlt_pkg::M_INT)) begin
                  nxt.mode = dlt_pkg::M_FRAC;
               end else if ((text_byte == dlt_pkg::CH_LO_E) ||
                            (text_byte == dlt_pkg::CH_UP_E)) begin
                  nxt.mode = dlt_pkg::M_EXP_E;
               end else begin
                  a_v = 1'b1;
                  a_r = at_start(cur, dlt_pkg::K_NUMBER, dlt_pkg::E_NONE, len_d);
                  idle_go = 1'b1;
               end
            end
            dlt_pkg::M_EXP_E: begin
               if ((text_byte == dlt_pkg::CH_PLUS) || (text_byte == dlt_pkg::CH_MINUS)) begin
                  nxt.mode = dlt_pkg::M_EXP_SIGN;
               end else if (dlt_pkg::is_digit(text_byte)) begin
                  nxt.mode = dlt_pkg::M_EXP_DIG;
               end else begin
                  a_v = 1'b1;
                  a_r = at_start(cur, dlt_pkg::K_ERROR, dlt_pkg::E_BAD_EXP, '0);
                  nxt.mode = dlt_pkg::M_HALT;
               end
            end
            dlt_pkg::M_EXP_SIGN: begin
               if (dlt_pkg::is_digit(text_byte)) begin
                  nxt.mode = dlt_pkg::M_EXP_DIG;
               end else begin
                  a_v = 1'b1;
                  a_r = at_start(cur, dlt_pkg::K_ERROR, dlt_pkg::E_BAD_EXP, '0);
                  nxt.mode = dlt_pkg::M_HALT;
               end
            end
            dlt_pkg::M_EXP_DIG: begin
               if (!dlt_pkg::is_digit(text_byte)) begin
                  a_v = 1'b1;
                  a_r = at_start(cur, dlt_pkg::K_NUMBER, dlt_pkg::E_NONE, len_d);
                  idle_go = 1'b1;
               end
            end
            dlt_pkg::M_IDENT: begin
               if (!dlt_pkg::is_word(text_byte)) begin
                  a_v = 1'b1;
                  a_r = at_start(cur, dlt_pkg::K_IDENT, dlt_pkg::E_NONE, len_d);
                  idle_go = 1'b1;
               end
            end
            default: begin
               idle_go = 1'b1;
            end
         endcase
      end

      // fresh scan of the byte between tokens
      if (idle_go) begin
         nxt.mode = dlt_pkg::M_IDLE;
         if (dlt_pkg::is_space(text_byte)) begin
            nxt.mode = dlt_pkg::M_IDLE;
         end else if (text_byte == dlt_pkg::CH_HASH) begin
            nxt.mode = dlt_pkg::M_COMMENT;
         end else if ((text_byte == dlt_pkg::CH_QUOTE) || dlt_pkg::is_digit(text_byte) ||
                      (text_byte == dlt_pkg::CH_PLUS) || (text_byte == dlt_pkg::CH_MINUS) ||
                      dlt_pkg::is_word(text_byte)) begin
            nxt.ts_off  = cur.off;
            nxt.ts_line = cur.line;
            nxt.ts_col  = cur.col;
            if (text_byte == dlt_pkg::CH_QUOTE) begin
               nxt.mode = dlt_pkg::M_STR;
            end else if (dlt_pkg::is_digit(text_byte)) begin
               nxt.mode = dlt_pkg::M_INT;
            end else if ((text_byte == dlt_pkg::CH_PLUS) ||
                         (text_byte == dlt_pkg::CH_MINUS)) begin
               nxt.mode = dlt_pkg::M_SIGN;
            end else begin
               nxt.mode = dlt_pkg::M_IDENT;
            end
         end else if (sk != dlt_pkg::K_END) begin
            b_v = 1'b1;
            b_r = at_here(cur, sk, dlt_pkg::E_NONE, 1'b1);
         end else begin
            b_v = 1'b1;
            b_r = at_here(cur, dlt_pkg::K_ERROR, dlt_pkg::E_UNEXPECTED, 1'b0);
            nxt.mode = dlt_pkg::M_HALT;
         end
      end

      // finish the pending token at end of text
      if (end_go) begin
         case (cur.mode)
            dlt_pkg::M_STR, dlt_pkg::M_STR_ESC: begin
               a_v = 1'b1;
               a_r = at_start(cur, dlt_pkg::K_ERROR, dlt_pkg::E_OPEN_STR, '0);
               end_err = 1'b1;
            end
            dlt_pkg::M_SIGN: begin
               a_v = 1'b1;
               a_r = at_start(cur, dlt_pkg::K_ERROR, dlt_pkg::E_UNEXPECTED, '0);
               end_err = 1'b1;
            end
            dlt_pkg::M_EXP_E, dlt_pkg::M_EXP_SIGN: begin
               a_v = 1'b1;
               a_r = at_start(cur, dlt_pkg::K_ERROR, dlt_pkg::E_BAD_EXP, '0);
               end_err = 1'b1;
            end
            dlt_pkg::M_INT, dlt_pkg::M_FRAC, dlt_pkg::M_EXP_DIG: begin
               a_v = 1'b1;
               a_r = at_start(cur, dlt_pkg::K_NUMBER, dlt_pkg::E_NONE, len_d);
            end
            dlt_pkg::M_IDENT: begin
               a_v = 1'b1;
               a_r = at_start(cur, dlt_pkg::K_IDENT, dlt_pkg::E_NONE, len_d);
            end
            default: begin
               a_v = 1'b0;
            end
         endcase
         if (!end_err) begin
            b_v = 1'b1;
            b_r = at_here(cur, dlt_pkg::K_END, dlt_pkg::E_NONE, 1'b0);
         end
         if (end_err) begin
            nxt.mode = dlt_pkg::M_HALT;
         end
         if (!end_of_text && !end_err) begin
            clear = 1'b1;
         end
      end

      // step the position counters
      if (do_adv) begin
         nxt.off = cur.off + 1'b1;
         if (text_byte == dlt_pkg::CH_NL) begin
            nxt.line = (cur.line != '1) ? cur.line + 1'b1 : cur.line;
            nxt.col  = dlt_pkg::POSITION_BITS'(1);
         end else begin
            nxt.col  = (cur.col != '1) ? cur.col + 1'b1 : cur.col;
         end
      end

      if (clear) begin
         nxt.mode    = dlt_pkg::M_IDLE;
         nxt.off     = '0;
         nxt.line    = dlt_pkg::POSITION_BITS'(1);
         nxt.col     = dlt_pkg::POSITION_BITS'(1);
         nxt.ts_off  = '0;
         nxt.ts_line = dlt_pkg::POSITION_BITS'(1);
         nxt.ts_col  = dlt_pkg::POSITION_BITS'(1);
      end
   end

   // pack in delivery order and flag the final beat
   always_comb begin
      res.count  = {1'b0, a_v} + {1'b0, b_v};
      res.first  = a_v ? a_r : b_r;
      res.second = b_r;
      res.first.last  = !(a_v && b_v);
      res.second.last = 1'b1;
   end

endmodule

// ===== sv/dlt_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// dlt_rsp_queue: result beat queue
// Takes up to two beats per cycle, pops one per cycle while head_take holds.
// ----------------------------------------------------------------------------
module dlt_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dlt_pkg::scan_out_type push_data,
   output logic                  room_for_two,
   output logic                  head_valid,
   input  logic                  head_take,
   output dlt_pkg::result_type   head
);

   dlt_pkg::result_type               slot_ff [dlt_pkg::QUEUE_DEPTH];
   logic [dlt_pkg::QPTR_BITS-1:0]     wr_ptr_ff;
   logic [dlt_pkg::QPTR_BITS-1:0]     wr_ptr_in;
   logic [dlt_pkg::QPTR_BITS-1:0]     rd_ptr_ff;
   logic [dlt_pkg::QPTR_BITS-1:0]     rd_ptr_in;
   logic [dlt_pkg::QCNT_BITS-1:0]     count_ff;
   logic [dlt_pkg::QCNT_BITS-1:0]     count_in;
   logic [1:0]                        n_push;
   logic                              pop;

   assign n_push       = push ? push_data.count : 2'd0;
   assign pop          = head_valid && head_take;
   assign head_valid   = (count_ff != '0);
   assign head         = slot_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= dlt_pkg::QCNT_BITS'(dlt_pkg::QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + dlt_pkg::QPTR_BITS'(n_push);
   assign rd_ptr_in = rd_ptr_ff + dlt_pkg::QPTR_BITS'(pop);
   assign count_in  = count_ff + dlt_pkg::QCNT_BITS'(n_push)
                      - dlt_pkg::QCNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_data.first;
      end
      if (n_push == 2'd2) begin
         slot_ff[wr_ptr_ff + 1'b1] <= push_data.second;
      end
   end

endmodule
